>>> hw/rtl/spi_pkg.sv
// Shared types and codes of the snapshot position interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package spi_pkg;

   localparam logic [1:0] ACT_SNAP  = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_EVENT = 2'd2;

   localparam int unsigned LANES = 3;
   localparam int unsigned DELTA_WIDTH = 16;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic start;
      logic zero_span;
   } lane_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/spi_lane.sv
// One interpolation lane: bit-serial exact floor(|next - current| * elapsed / span).
// Depends on spi_pkg for the lane command struct.
`default_nettype none

module spi_lane
   import spi_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lane_cmd_type           cmd,
   input  wire logic [COORD_WIDTH-1:0] cur_i,
   input  wire logic [COORD_WIDTH-1:0] nxt_i,
   input  wire logic [TIME_WIDTH-2:0]  elapsed_i,
   input  wire logic [TIME_WIDTH-2:0]  span_i,
   output logic                        done_o,
   output logic [COORD_WIDTH-1:0]      result_o
);

   localparam int STEPS = COORD_WIDTH + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [CNT_W-1:0]       cnt_ff;
   logic [COORD_WIDTH:0]   mag_ff, q_ff, q_in;
   logic [TIME_WIDTH-2:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-2:0]  e_ff, span_ff;
   logic [COORD_WIDTH-1:0] cur_ff;
   logic                   neg_ff, zero_ff;

   logic [COORD_WIDTH:0]   diff, mag;
   logic [TIME_WIDTH:0]    t, s1, s2, t_red;
   logic [1:0]             digit;
   logic [COORD_WIDTH:0]   cur_x, sum;

   assign diff = {nxt_i[COORD_WIDTH-1], nxt_i} - {cur_i[COORD_WIDTH-1], cur_i};
   assign mag  = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;

   always_comb begin
      t  = {1'b0, rem_ff, 1'b0} + (mag_ff[COORD_WIDTH] ? {2'b00, e_ff} : '0);
      s1 = {2'b00, span_ff};
      s2 = {1'b0, span_ff, 1'b0};
      if (t >= s2) begin
         t_red = t - s2;
         digit = 2'd2;
      end else if (t >= s1) begin
         t_red = t - s1;
         digit = 2'd1;
      end else begin
         t_red = t;
         digit = 2'd0;
      end
      rem_in = t_red[TIME_WIDTH-2:0];
      q_in   = {q_ff[COORD_WIDTH-1:0], 1'b0} + {{(COORD_WIDTH-1){1'b0}}, digit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mag_ff  <= mag;
         q_ff    <= '0;
         rem_ff  <= '0;
         e_ff    <= elapsed_i;
         span_ff <= span_i;
         cur_ff  <= cur_i;
         neg_ff  <= diff[COORD_WIDTH];
         zero_ff <= cmd.zero_span;
      end else if (cnt_ff != '0) begin
         mag_ff <= {mag_ff[COORD_WIDTH-1:0], 1'b0};
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign cur_x    = {cur_ff[COORD_WIDTH-1], cur_ff};
   assign sum      = neg_ff ? (cur_x - q_ff) : (cur_x + q_ff);
   assign result_o = zero_ff ? cur_ff : sum[COORD_WIDTH-1:0];
   assign done_o   = (cnt_ff == '0);

endmodule

`default_nettype wire

>>> hw/rtl/spi_merge.sv
// Output stage: gathers the lane results into one registered result transfer.
// Depends on spi_pkg for the lane count.
`default_nettype none

module spi_merge
   import spi_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push_i,
   input  wire logic [LANES-1:0][COORD_WIDTH-1:0]  lane_res_i,
   output logic                                    ready_o,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_pos_z
);

   logic                                  valid_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0]     pos_ff;

   assign ready_o = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push_i) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         pos_ff <= lane_res_i;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];

endmodule

`default_nettype wire

>>> hw/rtl/snapshot_position_interpolator.sv
// Top level: snapshot bookkeeping, tick control and three interpolation lanes.
// Depends on spi_pkg, spi_lane and spi_merge.
//
//   channel   prefix  direction  payload
//   input     req_    in         action, snap_time, snap_x/y/z, tick_delta
//   result    rsp_    out        pos_x, pos_y, pos_z
//
// Snapshot, event, ignored and non-emitting tick items are accepted while idle.
// An emitting tick loads the lanes, runs COORD_WIDTH + 1 shift-add-divide steps
// in each lane, then merges; no new item is accepted until it has merged.
// Reset is synchronous; control and snapshot state clear, lane data does not.
// A held result stalls nothing until the lanes finish the next emitting tick;
// that tick then waits for the output register to free up.
`default_nettype none

module snapshot_position_interpolator
   import spi_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic signed [TIME_WIDTH-1:0]  req_snap_time,
   input  wire logic signed [COORD_WIDTH-1:0] req_snap_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_snap_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_snap_z,
   input  wire logic [DELTA_WIDTH-1:0]        req_tick_delta,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_pos_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_pos_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_pos_z
);

   localparam int PAD_W = TIME_WIDTH + 1 - DELTA_WIDTH;

   state_type state_ff, state_in;

   logic                                 pending_ff;
   logic [TIME_WIDTH-1:0]                pend_time_ff, cur_time_ff, nxt_time_ff, span_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0]    pend_pt_ff, cur_pt_ff, nxt_pt_ff;
   logic [TIME_WIDTH-2:0]                elapsed_ff, elapsed_in;

   logic                                 accept;
   logic [LANES-1:0][COORD_WIDTH-1:0]    snap_pt, cur_pt_new, nxt_pt_new;
   logic [TIME_WIDTH-1:0]                cur_time_new, nxt_time_new, span_new;
   logic [TIME_WIDTH-2:0]                elapsed_new;
   logic [TIME_WIDTH:0]                  elapsed_sum;
   logic                                 emit, is_tick;
   logic                                 lanes_done, merge_ready, push;
   lane_cmd_type                         lane_cmd;
   logic [LANES-1:0]                     lane_done;
   logic [LANES-1:0][COORD_WIDTH-1:0]    lane_res;

   assign accept  = req_valid && req_ready;
   assign snap_pt = {req_snap_z, req_snap_y, req_snap_x};
   assign is_tick = (req_action == ACT_TICK);

   always_comb begin
      if (pending_ff) begin
         cur_time_new = nxt_time_ff;
         nxt_time_new = pend_time_ff;
         span_new     = pend_time_ff - nxt_time_ff;
         elapsed_new  = '0;
         cur_pt_new   = nxt_pt_ff;
         nxt_pt_new   = pend_pt_ff;
      end else begin
         cur_time_new = cur_time_ff;
         nxt_time_new = nxt_time_ff;
         span_new     = span_ff;
         elapsed_new  = elapsed_ff;
         cur_pt_new   = cur_pt_ff;
         nxt_pt_new   = nxt_pt_ff;
      end
      emit        = !span_new[TIME_WIDTH-1] && ({1'b0, elapsed_new} <= span_new);
      elapsed_sum = {2'b00, elapsed_new} + {{PAD_W{1'b0}}, req_tick_delta};
      elapsed_in  = (elapsed_sum[TIME_WIDTH:TIME_WIDTH-1] != 2'b00) ? '1
                                                                     : elapsed_sum[TIME_WIDTH-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         pend_time_ff <= '0;
         cur_time_ff  <= '0;
         nxt_time_ff  <= '0;
         span_ff      <= '0;
         elapsed_ff   <= '0;
         pend_pt_ff   <= '0;
         cur_pt_ff    <= '0;
         nxt_pt_ff    <= '0;
      end else if (accept) begin
         unique case (req_action)
            ACT_SNAP: begin
               pending_ff   <= 1'b1;
               pend_time_ff <= req_snap_time;
               pend_pt_ff   <= snap_pt;
            end
            ACT_EVENT: begin
               pending_ff <= 1'b1;
            end
            ACT_TICK: begin
               pending_ff  <= 1'b0;
               cur_time_ff <= cur_time_new;
               nxt_time_ff <= nxt_time_new;
               span_ff     <= span_new;
               elapsed_ff  <= elapsed_in;
               cur_pt_ff   <= cur_pt_new;
               nxt_pt_ff   <= nxt_pt_new;
            end
            default: begin
               pending_ff <= pending_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_tick && emit) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (lanes_done && merge_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready          = 1'b0;
      push               = 1'b0;
      lane_cmd.start     = 1'b0;
      lane_cmd.zero_span = (span_new == '0);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            lane_cmd.start = req_valid && is_tick && emit;
         end
         ST_RUN: begin
            push = lanes_done && merge_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign lanes_done = &lane_done;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      spi_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .TIME_WIDTH  (TIME_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (lane_cmd),
         .cur_i     (cur_pt_new[g]),
         .nxt_i     (nxt_pt_new[g]),
         .elapsed_i (elapsed_new),
         .span_i    (span_new[TIME_WIDTH-2:0]),
         .done_o    (lane_done[g]),
         .result_o  (lane_res[g])
      );
   end

   spi_merge #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .lane_res_i (lane_res),
      .ready_o    (merge_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pos_x  (rsp_pos_x),
      .rsp_pos_y  (rsp_pos_y),
      .rsp_pos_z  (rsp_pos_z)
   );

endmodule

`default_nettype wire

>>> hw/rtl/spi_checker.sv
// Port-level checks for the snapshot position interpolator, bound to the top level.
// Depends on spi_pkg for the action codes and the delta width.
`default_nettype none

module spi_checker
   import spi_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int TIME_WIDTH  = 32
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [1:0]                    req_action,
   input wire logic signed [TIME_WIDTH-1:0]  req_snap_time,
   input wire logic signed [COORD_WIDTH-1:0] req_snap_x,
   input wire logic signed [COORD_WIDTH-1:0] req_snap_y,
   input wire logic signed [COORD_WIDTH-1:0] req_snap_z,
   input wire logic [DELTA_WIDTH-1:0]        req_tick_delta,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [COORD_WIDTH-1:0] rsp_pos_x,
   input wire logic signed [COORD_WIDTH-1:0] rsp_pos_y,
   input wire logic signed [COORD_WIDTH-1:0] rsp_pos_z
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x)
                                 && $stable(rsp_pos_y) && $stable(rsp_pos_z))
      else $error("stalled result transfer changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_action)
                                 && $stable(req_snap_time) && $stable(req_snap_x)
                                 && $stable(req_snap_y) && $stable(req_snap_z)
                                 && $stable(req_tick_delta))
      else $error("stalled input transfer changed");

   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a busy interval");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != ACT_TICK && !rsp_valid |=> !rsp_valid)
      else $error("non-tick transfer produced a result");

endmodule

bind snapshot_position_interpolator spi_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .TIME_WIDTH  (TIME_WIDTH)
) u_spi_checker (.*);

`default_nettype wire
